/* rtl/ptrs_pkg.sv */
`default_nettype none
package ptrs_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam logic [7:0] PENDING_MAX = 8'd255;

	localparam logic [1:0] OP_ADD      = 2'd0;
	localparam logic [1:0] OP_DELETE   = 2'd1;
	localparam logic [1:0] OP_TICK     = 2'd2;
	localparam logic [1:0] OP_DISPATCH = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_IDLE      = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_TCHK,
		S_DIV,
		S_REL
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_step;
		logic commit_hit;
		logic commit_miss;
		logic div_start;
		logic div_step;
		logic rel_apply;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op_tick;
		logic scan_hit;
		logic scan_last;
		logic div_needed;
		logic div_last;
		logic out_busy;
	} stat_t;

endpackage
`default_nettype wire

/* rtl/ptrs_ctrl.sv */
`default_nettype none
module ptrs_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ptrs_pkg::stat_t st,
	output ptrs_pkg::cmd_t     cmd
);

	ptrs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptrs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ptrs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = st.op_tick ? ptrs_pkg::S_TCHK : ptrs_pkg::S_SCAN;
				end
			end
			ptrs_pkg::S_SCAN: begin
				if (st.scan_hit) begin
					if (!st.out_busy) begin
						cmd.commit_hit = 1'b1;
						state_d        = ptrs_pkg::S_IDLE;
					end
				end else if (st.scan_last) begin
					if (!st.out_busy) begin
						cmd.commit_miss = 1'b1;
						state_d         = ptrs_pkg::S_IDLE;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ptrs_pkg::S_TCHK: begin
				if (st.div_needed) begin
					cmd.div_start = 1'b1;
					state_d       = ptrs_pkg::S_DIV;
				end else if (st.scan_last) begin
					if (!st.out_busy) begin
						cmd.commit_miss = 1'b1;
						state_d         = ptrs_pkg::S_IDLE;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ptrs_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = ptrs_pkg::S_REL;
				end
			end
			ptrs_pkg::S_REL: begin
				// Release is applied once; the slot then counts as handled.
				if (st.scan_last) begin
					if (!st.out_busy) begin
						cmd.rel_apply   = 1'b1;
						cmd.commit_miss = 1'b1;
						state_d         = ptrs_pkg::S_IDLE;
					end
				end else begin
					cmd.rel_apply = 1'b1;
					cmd.scan_step = 1'b1;
					state_d       = ptrs_pkg::S_TCHK;
				end
			end
			default: begin
				state_d = ptrs_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/ptrs_datapath.sv */
`default_nettype none
module ptrs_datapath #(
	parameter int NUM_SLOTS = ptrs_pkg::NUM_SLOTS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [1:0]    op,
	input  wire logic [7:0]    task_id,
	input  wire logic [15:0]   period,
	input  wire ptrs_pkg::cmd_t cmd,
	output ptrs_pkg::stat_t    st,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [1:0]         status,
	output logic [7:0]         out_task_id,
	output logic [2:0]         slot
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

	logic [7:0]    tid_q  [NUM_SLOTS];
	logic [15:0]   per_q  [NUM_SLOTS];
	logic [7:0]    pend_q [NUM_SLOTS];
	logic [31:0]   tick_q;
	logic [IW-1:0] ptr_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] k_q;
	logic [1:0]    op_q;
	logic [7:0]    id_q;
	logic [15:0]   per_in_q;
	logic [15:0]   rem_q;
	logic [4:0]    bit_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [7:0]    out_id_q;
	logic [2:0]    slot_q;

	logic [IW-1:0] cur_next;
	logic [16:0]   rem_sh;
	logic [16:0]   rem_sub;
	logic [IW+2:0] cur_ext;

	assign cur_next = (cur_q == LAST) ? '0 : cur_q + 1'b1;
	assign rem_sh   = {rem_q, tick_q[bit_q]};
	assign rem_sub  = rem_sh - {1'b0, per_q[cur_q]};
	assign cur_ext  = (IW + 3)'(cur_q);

	always_comb begin
		st            = '0;
		st.op_tick    = (op == ptrs_pkg::OP_TICK);
		st.scan_last  = (k_q == LAST);
		st.div_needed = (tid_q[cur_q] != 8'd0) && (per_q[cur_q] != 16'd0);
		st.div_last   = (bit_q == 5'd0);
		st.out_busy   = out_valid_q && !out_ready;
		case (op_q)
			ptrs_pkg::OP_ADD:    st.scan_hit = (id_q == 8'd0) || (tid_q[cur_q] == 8'd0);
			ptrs_pkg::OP_DELETE: st.scan_hit = (tid_q[cur_q] == id_q);
			ptrs_pkg::OP_DISPATCH: st.scan_hit = (pend_q[cur_q] != 8'd0);
			default:             st.scan_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				tid_q[i]  <= '0;
				per_q[i]  <= '0;
				pend_q[i] <= '0;
			end
			tick_q      <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit_hit || cmd.commit_miss) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load && (op == ptrs_pkg::OP_TICK)) begin
				tick_q <= tick_q + 32'd1;
			end
			if (cmd.rel_apply && (rem_q == 16'd0) && (pend_q[cur_q] != ptrs_pkg::PENDING_MAX)) begin
				pend_q[cur_q] <= pend_q[cur_q] + 8'd1;
			end
			if (cmd.commit_hit) begin
				case (op_q)
					ptrs_pkg::OP_ADD: begin
						if (id_q != 8'd0) begin
							tid_q[cur_q]  <= id_q;
							per_q[cur_q]  <= per_in_q;
							pend_q[cur_q] <= '0;
						end
					end
					ptrs_pkg::OP_DELETE: begin
						tid_q[cur_q]  <= '0;
						per_q[cur_q]  <= '0;
						pend_q[cur_q] <= '0;
					end
					ptrs_pkg::OP_DISPATCH: begin
						pend_q[cur_q] <= pend_q[cur_q] - 8'd1;
						ptr_q         <= cur_next;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			id_q     <= task_id;
			per_in_q <= period;
			k_q      <= '0;
			cur_q    <= (op == ptrs_pkg::OP_DISPATCH) ? ptr_q : '0;
		end
		if (cmd.scan_step) begin
			k_q   <= k_q + 1'b1;
			cur_q <= cur_next;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			bit_q <= 5'd31;
		end
		if (cmd.div_step) begin
			rem_q <= rem_sub[16] ? rem_sh[15:0] : rem_sub[15:0];
			bit_q <= bit_q - 5'd1;
		end
		if (cmd.commit_hit) begin
			status_q <= ptrs_pkg::ST_OK;
			if ((op_q == ptrs_pkg::OP_ADD) && (id_q == 8'd0)) begin
				slot_q <= '0;
			end else begin
				slot_q <= cur_ext[2:0];
			end
			out_id_q <= (op_q == ptrs_pkg::OP_DISPATCH) ? tid_q[cur_q] : 8'd0;
		end
		if (cmd.commit_miss) begin
			slot_q   <= '0;
			out_id_q <= '0;
			case (op_q)
				ptrs_pkg::OP_ADD:      status_q <= ptrs_pkg::ST_FULL;
				ptrs_pkg::OP_DELETE:   status_q <= ptrs_pkg::ST_NOT_FOUND;
				ptrs_pkg::OP_DISPATCH: status_q <= ptrs_pkg::ST_IDLE;
				default:               status_q <= ptrs_pkg::ST_OK;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_task_id = out_id_q;
	assign slot        = slot_q;

endmodule
`default_nettype wire

/* rtl/periodic_task_release_scheduler_top.sv */
`default_nettype none
// Channel | Handshake           | Word
// --------+---------------------+------------------------------------
// input   | in_valid / in_ready | op, task_id, period
// output  | out_valid/out_ready | status, out_task_id, slot
//
// One word is worked at a time. Add, delete and dispatch walk the slot table
// one slot per cycle, at most NUM_SLOTS slots per word. A tick walks the
// slots too and runs a bit-serial remainder of the tick count for every
// occupied slot with a nonzero period; that remainder unit sets the rate.
// Reset is asynchronous and clears the whole table, the tick count and the
// scan pointer at once. A new word is taken while a result still waits in
// the output register; only the commit of the next result waits for that
// register to drain.
module periodic_task_release_scheduler_top #(
	parameter int NUM_SLOTS = ptrs_pkg::NUM_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  task_id,
	input  wire logic [15:0] period,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [7:0]       out_task_id,
	output logic [2:0]       slot
);

	ptrs_pkg::cmd_t  cmd;
	ptrs_pkg::stat_t st;

	// The controller sequences the walk; the datapath owns the table.
	ptrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	ptrs_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.task_id     (task_id),
		.period      (period),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.out_task_id (out_task_id),
		.slot        (slot)
	);

	// After a word is taken the block is not ready in the cycle after.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on two cycles in a row");

	// Only a successful dispatch reports a task id.
	a_id_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_task_id != 8'd0) |-> (status == ptrs_pkg::ST_OK))
		else $error("task id reported with failing status");

	// A failing result never names a slot.
	a_fail_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ptrs_pkg::ST_OK) |-> (slot == 3'd0))
		else $error("failing result names a slot");

endmodule
`default_nettype wire

/* test/periodic_task_release_scheduler_top_test.sv */
`default_nettype none
// Testbench for the periodic task release scheduler. Words are queued by an
// initial block, driven by a clocked driver with random idle bursts, and the
// results are checked by a clocked monitor against a behavioral table model.
module periodic_task_release_scheduler_top_test;

	localparam int SLOTS = 8;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 400;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  task_id;
		logic [15:0] period;
	} sched_cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] task_id;
		logic [2:0] slot;
	} sched_res_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [7:0]  task_id;
	logic [15:0] period;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [7:0]  out_task_id;
	logic [2:0]  slot;

	periodic_task_release_scheduler_top #(.NUM_SLOTS(SLOTS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.task_id(task_id),
		.period(period),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_task_id(out_task_id),
		.slot(slot)
	);

	// The model's copy of the scheduler table.
	logic [7:0]  tbl_id[SLOTS];
	logic [15:0] tbl_period[SLOTS];
	logic [7:0]  tbl_runs[SLOTS];
	logic [31:0] tick_now;
	int          next_scan;

	sched_cmd_t pending_words[$];
	sched_res_t expected_results[$];
	bit         stimulus_done;
	bit         quiet_phase;
	bit         hold_off_req;
	int         errors;
	int         idle_cycles;

	// Works out the result of one word and updates the table model.
	function automatic sched_res_t schedule_word(sched_cmd_t w);
		sched_res_t r;
		int j;
		r = '0;
		case (w.op)
			ptrs_pkg::OP_ADD: begin
				if (w.task_id != 8'd0) begin
					r.status = ptrs_pkg::ST_FULL;
					for (int i = 0; i < SLOTS; i++) begin
						if (tbl_id[i] == 8'd0) begin
							tbl_id[i] = w.task_id;
							tbl_period[i] = w.period;
							tbl_runs[i] = '0;
							r.status = ptrs_pkg::ST_OK;
							r.slot = i[2:0];
							break;
						end
					end
				end
			end
			ptrs_pkg::OP_DELETE: begin
				r.status = ptrs_pkg::ST_NOT_FOUND;
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_id[i] == w.task_id) begin
						tbl_id[i] = '0;
						tbl_period[i] = '0;
						tbl_runs[i] = '0;
						r.status = ptrs_pkg::ST_OK;
						r.slot = i[2:0];
						break;
					end
				end
			end
			ptrs_pkg::OP_TICK: begin
				tick_now = tick_now + 32'd1;
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_id[i] != 8'd0 && tbl_period[i] != 16'd0 &&
							(tick_now % {16'd0, tbl_period[i]}) == 32'd0 &&
							tbl_runs[i] != ptrs_pkg::PENDING_MAX) begin
						tbl_runs[i] = tbl_runs[i] + 8'd1;
					end
				end
			end
			default: begin
				r.status = ptrs_pkg::ST_IDLE;
				j = next_scan;
				for (int k = 0; k < SLOTS; k++) begin
					if (tbl_runs[j] != 8'd0) begin
						tbl_runs[j] = tbl_runs[j] - 8'd1;
						next_scan = (j + 1) % SLOTS;
						r.status = ptrs_pkg::ST_OK;
						r.task_id = tbl_id[j];
						r.slot = j[2:0];
						break;
					end
					j = (j + 1) % SLOTS;
				end
			end
		endcase
		return r;
	endfunction

	function automatic void queue_word(logic [1:0] o, logic [7:0] id, logic [15:0] p);
		sched_cmd_t w;
		w.op = o;
		w.task_id = id;
		w.period = p;
		pending_words.push_back(w);
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stimulus: a directed opening, then random well-formed traffic.
	initial begin
		int pick;
		logic [7:0] ids[$];
		for (int i = 0; i < SLOTS; i++) begin
			tbl_id[i] = '0;
			tbl_period[i] = '0;
			tbl_runs[i] = '0;
		end
		tick_now = '0;
		next_scan = 0;
		// Empty table: dispatch finds nothing, delete misses, delete of zero hits slot 0.
		queue_word(ptrs_pkg::OP_DISPATCH, 8'd0, 16'd0);
		queue_word(ptrs_pkg::OP_DELETE, 8'd77, 16'd0);
		queue_word(ptrs_pkg::OP_DELETE, 8'd0, 16'hFFFF);
		// Add with id zero changes nothing.
		queue_word(ptrs_pkg::OP_ADD, 8'd0, 16'd1);
		// Extreme ids and periods, a zero period and a duplicate id.
		queue_word(ptrs_pkg::OP_ADD, 8'd255, 16'd1);
		queue_word(ptrs_pkg::OP_ADD, 8'd1, 16'hFFFF);
		queue_word(ptrs_pkg::OP_ADD, 8'd9, 16'd0);
		queue_word(ptrs_pkg::OP_ADD, 8'd9, 16'd2);
		queue_word(ptrs_pkg::OP_ADD, 8'hAA, 16'h5555);
		queue_word(ptrs_pkg::OP_ADD, 8'h55, 16'hAAAA);
		queue_word(ptrs_pkg::OP_ADD, 8'd3, 16'd3);
		queue_word(ptrs_pkg::OP_ADD, 8'd4, 16'd1);
		// Table is full now.
		queue_word(ptrs_pkg::OP_ADD, 8'd200, 16'd1);
		queue_word(ptrs_pkg::OP_DELETE, 8'd0, 16'd0);
		queue_word(ptrs_pkg::OP_TICK, 8'd0, 16'd0);
		queue_word(ptrs_pkg::OP_TICK, 8'd0, 16'd0);
		for (int i = 0; i < 5; i++) queue_word(ptrs_pkg::OP_DISPATCH, 8'd0, 16'd0);
		// Delete removes only the lowest of the duplicates.
		queue_word(ptrs_pkg::OP_DELETE, 8'd9, 16'd0);
		queue_word(ptrs_pkg::OP_DELETE, 8'd9, 16'd0);
		queue_word(ptrs_pkg::OP_DELETE, 8'd9, 16'd0);
		for (int i = 0; i < 1880; i++) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				ids.push_back(8'($urandom_range(1, 255)));
				queue_word(ptrs_pkg::OP_ADD, pick < 3 ? 8'd0 : ids[$],
					pick < 20 ? 16'($urandom_range(0, 6)) : 16'($urandom));
			end else if (pick < 40) begin
				if (ids.size() != 0 && pick < 36) begin
					int n;
					n = $urandom_range(ids.size() - 1);
					queue_word(ptrs_pkg::OP_DELETE, ids[n], 16'($urandom));
					ids.delete(n);
				end else begin
					queue_word(ptrs_pkg::OP_DELETE, 8'($urandom), 16'($urandom));
				end
			end else if (pick < 70) begin
				queue_word(ptrs_pkg::OP_TICK, 8'($urandom), 16'($urandom));
			end else begin
				queue_word(ptrs_pkg::OP_DISPATCH, 8'($urandom), 16'($urandom));
			end
		end
	end

	// Reset is applied once, at the start.
	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: holds each word until it is accepted, with idle bursts between words.
	int  gap_left;
	bit  loaded;
	int  sent;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= '0;
			task_id <= '0;
			period <= '0;
			gap_left = 0;
			loaded = 0;
			sent = 0;
			stimulus_done = 0;
			quiet_phase = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(schedule_word({op, task_id, period}));
				loaded = 0;
				sent++;
				if (sent > 1500) quiet_phase = 1;
				if (!quiet_phase && $urandom_range(3) == 0) gap_left = $urandom_range(1, 5);
			end
			if (!loaded) begin
				if (gap_left > 0 || pending_words.size() == 0) begin
					if (gap_left > 0) gap_left--;
					in_valid <= 1'b0;
					if (pending_words.size() == 0) stimulus_done = 1;
				end else begin
					sched_cmd_t w;
					w = pending_words.pop_front();
					op <= w.op;
					task_id <= w.task_id;
					period <= w.period;
					in_valid <= 1'b1;
					loaded = 1;
				end
			end
		end
	end

	// Receiver readiness: random stall bursts, plus one long hold-off early on
	// so the output register fills and the block stalls its input.
	int stall_left;
	int long_hold;
	bit long_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			long_hold = 0;
			long_done = 0;
		end else begin
			if (!long_done && sent == 40) begin
				long_hold = 3000;
				long_done = 1;
			end
			if (long_hold > 0) begin
				long_hold--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet_phase && $urandom_range(5) == 0) begin
				stall_left = $urandom_range(0, 4);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected word status=%0d id=%0d slot=%0d",
					$time, status, out_task_id, slot);
				errors++;
			end else begin
				sched_res_t e;
				e = expected_results.pop_front();
				if (status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status, status);
					errors++;
				end
				if (out_task_id !== e.task_id) begin
					$display("%0t: out_task_id expected %0d actual %0d",
						$time, e.task_id, out_task_id);
					errors++;
				end
				if (slot !== e.slot) begin
					$display("%0t: slot expected %0d actual %0d", $time, e.slot, slot);
					errors++;
				end
			end
		end
	end

	// Watchdog: counts cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		wait (stimulus_done && expected_results.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0 && !out_valid) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
rtl/ptrs_pkg.sv
rtl/ptrs_ctrl.sv
rtl/ptrs_datapath.sv
rtl/periodic_task_release_scheduler_top.sv
test/periodic_task_release_scheduler_top_test.sv
